@@ hdl/jpid_pkg.sv @@
// ----------------------------------------------------------------------------
// jpid_pkg: shared types and constants for the joint PID controller
// Field widths, fixed-point limits, register indexes and the stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package jpid_pkg;

  localparam int ANGLE_W = 16;   // Q3.12 angle and torque
  localparam int ERR_W   = 17;   // exact setpoint minus angle
  localparam int RATE_W  = 27;   // angle step times 1000
  localparam int SUM_W   = 32;   // integral
  localparam int GAIN_W  = 16;   // unsigned Q8.8
  localparam int WIN_W   = 15;   // integration window
  localparam int PHASE_W = 11;   // schedule counter
  localparam int P_W     = 34;   // 17s x 17s
  localparam int D_W     = 44;   // 17s x 27s
  localparam int I_W     = 49;   // 17s x 32s
  localparam int ACC_W   = 52;   // exact Q.20 sum
  localparam int RND_SH  = 8;    // Q.20 to Q.12
  localparam int RND_W   = ACC_W - RND_SH;

  localparam int TAU_LIMIT = 20480;      // 5.0 in Q3.12
  localparam int TORQ_MAX  = 32767;
  localparam int TORQ_MIN  = -32768;
  localparam int RND_HALF  = 128;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd10240;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd1024;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DERIV_GAIN   = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_INTEG_WINDOW = 3'd3,
    REG_TARGET_ANGLE = 3'd4,
    REG_PID_MODE     = 3'd5
  } cfg_reg_t;

  // Values handed from the front stage to the torque datapath.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [RATE_W-1:0] rate;
    logic signed [SUM_W-1:0]  esum;
  } stage_t;

endpackage

`default_nettype wire

@@ hdl/jpid_torque.sv @@
// ----------------------------------------------------------------------------
// jpid_torque: gain products, rounding and torque limit
// Registers the three gain products, then sums, rounds and clamps them.
// ----------------------------------------------------------------------------
`default_nettype none

module jpid_torque (
  input  wire logic                          clk,
  input  wire logic                          ld,
  input  wire jpid_pkg::stage_t              stage_i,
  input  wire logic [jpid_pkg::GAIN_W-1:0]   prop_gain,
  input  wire logic [jpid_pkg::GAIN_W-1:0]   deriv_gain,
  input  wire logic [jpid_pkg::GAIN_W-1:0]   integ_gain,
  input  wire logic                          pid_mode,
  output logic signed [jpid_pkg::ANGLE_W-1:0] torque_o
);
  import jpid_pkg::*;

  logic signed [GAIN_W:0]  pg_s, dg_s, ig_s;
  logic signed [P_W-1:0]   p_nxt, p_r;
  logic signed [D_W-1:0]   d_nxt, d_r;
  logic signed [I_W-1:0]   i_nxt, i_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [RND_W-1:0] rnd, lo, hi, lim;

  assign pg_s = $signed({1'b0, prop_gain});
  assign dg_s = $signed({1'b0, deriv_gain});
  assign ig_s = $signed({1'b0, integ_gain});

  assign p_nxt = P_W'(pg_s) * P_W'(stage_i.err);
  assign d_nxt = D_W'(dg_s) * D_W'(stage_i.rate);
  // PD mode leaves the integral term out
  assign i_nxt = pid_mode ? (I_W'(ig_s) * I_W'(stage_i.esum)) : '0;

  always_ff @(posedge clk) begin
    if (ld) begin
      p_r <= p_nxt;
      d_r <= d_nxt;
      i_r <= i_nxt;
    end
  end

  always_comb begin
    acc = ACC_W'(p_r) - ACC_W'(d_r) + ACC_W'(i_r) + ACC_W'(RND_HALF);
    rnd = acc[ACC_W-1:RND_SH];   // floor shift: rounds half up
    lo  = pid_mode ? RND_W'(-TAU_LIMIT) : RND_W'(TORQ_MIN);
    hi  = pid_mode ? RND_W'(TAU_LIMIT)  : RND_W'(TORQ_MAX);
    if (rnd < lo) begin
      lim = lo;
    end else if (rnd > hi) begin
      lim = hi;
    end else begin
      lim = rnd;
    end
    torque_o = lim[ANGLE_W-1:0];
  end

endmodule

`default_nettype wire

@@ hdl/joint_pid_with_conditional_integral_top.sv @@
// ----------------------------------------------------------------------------
// joint_pid_with_conditional_integral_top: one joint's PID controller
// Per tick: error, rate, windowed saturating integral, gain products,
// rounding to Q3.12 and a mode-dependent torque clamp; setpoint schedule.
// ----------------------------------------------------------------------------
//
//  port group   direction  beat contents
//  in_*         sink       in_measured_angle, signed Q3.12 radians
//  out_*        source     out_torque, signed Q3.12
//  cfg_*        sink       cfg_addr register index, cfg_wdata value
//
//  One beat in, one beat out. out_valid rises once the beat has passed three
//  register stages; a new beat can be taken every cycle unless in_stall is high.
//  The controller state (last angle, integral, held setpoint, schedule count)
//  updates in the accept cycle, so the next beat already sees the new integral.
//  rst_n is synchronous: it clears the pipeline and state, resets the registers.
//  out_stall backs the three stages up; in_stall rises only when all are full.
//
`default_nettype none

module joint_pid_with_conditional_integral_top #(
  parameter int REST_TICKS  = 1000,
  parameter int CYCLE_TICKS = 2000
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [jpid_pkg::ANGLE_W-1:0] in_measured_angle,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [jpid_pkg::ANGLE_W-1:0]      out_torque,
  input  wire logic                                cfg_we,
  input  wire logic [jpid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [jpid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import jpid_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]         prop_gain_r, deriv_gain_r, integ_gain_r;
  logic [WIN_W-1:0]          integ_window_r;
  logic signed [ANGLE_W-1:0] target_angle_r;
  logic                      pid_mode_r;

  // controller state
  logic signed [ANGLE_W-1:0] last_angle_r, held_r, held_nxt;
  logic signed [SUM_W-1:0]   esum_r, esum_nxt;
  logic [PHASE_W-1:0]        phase_r, phase_nxt;

  // pipeline control
  logic s1_v_r, s2_v_r, out_valid_r;
  logic out_ready, s2_ready, s1_ready, in_acc;

  // front stage datapath
  logic signed [ERR_W-1:0]   err, diff;
  logic [ERR_W-1:0]          mag;
  logic signed [RATE_W-1:0]  diff_x, rate;
  logic signed [SUM_W:0]     sum_x;
  stage_t                    s1_nxt, s1_r;
  logic signed [ANGLE_W-1:0] torque_nxt, out_torque_r;

  // Each stage moves when the one after it is empty or moving.
  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_acc    = in_valid && s1_ready;

  assign out_valid  = out_valid_r;
  assign out_torque = out_torque_r;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= PROP_GAIN_RST;
      deriv_gain_r   <= DERIV_GAIN_RST;
      integ_gain_r   <= '0;
      integ_window_r <= '0;
      target_angle_r <= '0;
      pid_mode_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PROP_GAIN:    prop_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_WINDOW: integ_window_r <= cfg_wdata[WIN_W-1:0];
        REG_TARGET_ANGLE: target_angle_r <= $signed(cfg_wdata[ANGLE_W-1:0]);
        REG_PID_MODE:     pid_mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Front stage: error, rate, integral and schedule for the incoming beat.
  always_comb begin
    err    = ERR_W'(held_r) - ERR_W'(in_measured_angle);
    diff   = ERR_W'(in_measured_angle) - ERR_W'(last_angle_r);
    // times 1000 = 1024 - 16 - 8
    diff_x = RATE_W'(diff);
    rate   = (diff_x <<< 10) - (diff_x <<< 4) - (diff_x <<< 3);
    mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    // saturating integral, only inside the window
    sum_x = (SUM_W+1)'(esum_r) + (SUM_W+1)'(err);
    if (mag < ERR_W'(integ_window_r)) begin
      if (sum_x[SUM_W] != sum_x[SUM_W-1]) begin
        esum_nxt = sum_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        esum_nxt = sum_x[SUM_W-1:0];
      end
    end else begin
      esum_nxt = esum_r;
    end

    // setpoint for the next tick, then advance the schedule
    held_nxt  = (phase_r < PHASE_W'(REST_TICKS)) ? '0 : target_angle_r;
    phase_nxt = (phase_r > PHASE_W'(CYCLE_TICKS)) ? PHASE_W'(1) : phase_r + PHASE_W'(1);

    s1_nxt.err  = err;
    s1_nxt.rate = rate;
    s1_nxt.esum = esum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_angle_r <= '0;
      esum_r       <= '0;
      held_r       <= '0;
      phase_r      <= '0;
    end else if (in_acc) begin
      last_angle_r <= in_measured_angle;
      esum_r       <= esum_nxt;
      held_r       <= held_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // Stage valids: advance when the next stage frees up, otherwise hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ready) begin
        out_valid_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (out_ready && s2_v_r) begin
      out_torque_r <= torque_nxt;
    end
  end

  // Products register on the s1 to s2 move; the sum and clamp feed the output.
  jpid_torque u_torque (
    .clk        (clk),
    .ld         (s2_ready && s1_v_r),
    .stage_i    (s1_r),
    .prop_gain  (prop_gain_r),
    .deriv_gain (deriv_gain_r),
    .integ_gain (integ_gain_r),
    .pid_mode   (pid_mode_r),
    .torque_o   (torque_nxt)
  );

  // The input side stalls only with every stage full and the output blocked.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_valid_r && out_stall))
    else $error("in_stall raised with room in the pipeline");

  // Controller state moves only on an accepted beat.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(esum_r) && $stable(phase_r) && $stable(last_angle_r)))
    else $error("controller state changed without an input beat");

  // The schedule counter wraps just past the cycle length.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(phase_r) <= CYCLE_TICKS + 1)
    else $error("schedule counter out of range");

endmodule

`default_nettype wire

@@ tb/joint_pid_with_conditional_integral_top_test.sv @@
// ----------------------------------------------------------------------------
// joint_pid_with_conditional_integral_top_test: torque checker for one joint
// Drives angle beats through the controller under random idling and stalls.
// A scoreboard class recomputes every torque from its own copy of the gains,
// window, setpoint schedule and integral, and compares beat by beat.
// ----------------------------------------------------------------------------
module joint_pid_with_conditional_integral_top_test;
  import jpid_pkg::*;

  localparam int REST_TICKS   = 1000;
  localparam int CYCLE_TICKS  = 2000;
  localparam int DRAIN_CYCLES = 8;            // pipeline is three deep, leave margin
  localparam int IDLE_HEAVY   = 69;
  localparam int IDLE_BOTH    = 37;
  localparam int SEG_BEATS    = 195;
  localparam int RUN_LIMIT    = 40_000_000;   // time units, far past the slowest run

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR_HI = 3'd7;

  // Scoreboard: holds the controller's state and registers and the queue of
  // torques still owed by the pipeline.
  class torque_board;
    localparam longint RATE_SCALE = 1000;
    localparam longint SUM_MAX    = 64'sd2147483647;
    localparam longint SUM_MIN    = -64'sd2147483648;
    localparam int     MAX_SHOWN  = 50;

    logic [GAIN_W-1:0]         kp, kd, ki;
    logic [WIN_W-1:0]          window;
    logic signed [ANGLE_W-1:0] target;
    logic                      mode;
    logic signed [ANGLE_W-1:0] prev_angle, setpoint;
    int                        integral;
    logic [PHASE_W-1:0]        tick;
    int                        rest_ticks, cycle_ticks;
    logic signed [ANGLE_W-1:0] torque_due[$];
    int unsigned               faults, beats;

    function new(int rest, int cycle);
      rest_ticks  = rest;
      cycle_ticks = cycle;
      kp = PROP_GAIN_RST;
      kd = DERIV_GAIN_RST;
      ki = '0;
      window = '0;
      target = '0;
      mode = 1'b1;
      prev_angle = '0;
      setpoint = '0;
      integral = 0;
      tick = '0;
      faults = 0;
      beats = 0;
    endfunction

    task report(string msg);
      faults++;
      if (faults <= MAX_SHOWN) $display("MISMATCH: %s", msg);
    endtask

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_PROP_GAIN:    kp = data;
        REG_DERIV_GAIN:   kd = data;
        REG_INTEG_GAIN:   ki = data;
        REG_INTEG_WINDOW: window = data[WIN_W-1:0];
        REG_TARGET_ANGLE: target = data;
        REG_PID_MODE:     mode = data[0];
        default: ;
      endcase
    endfunction

    // One control tick: update the state and queue the torque it yields.
    function void take_angle(logic signed [ANGLE_W-1:0] angle);
      longint rate, err, mag, acc, sum, tq, lo, hi;
      rate = (longint'(angle) - longint'(prev_angle)) * RATE_SCALE;
      err  = longint'(setpoint) - longint'(angle);
      mag  = (err < 0) ? -err : err;
      prev_angle = angle;
      if (mag < longint'(window)) begin
        sum = longint'(integral) + err;
        if (sum > SUM_MAX) sum = SUM_MAX;
        if (sum < SUM_MIN) sum = SUM_MIN;
        integral = int'(sum);
      end
      acc = longint'(kp) * err - longint'(kd) * rate;
      if (mode) begin
        acc += longint'(ki) * longint'(integral);
        lo = -TAU_LIMIT;
        hi = TAU_LIMIT;
      end else begin
        lo = TORQ_MIN;
        hi = TORQ_MAX;
      end
      tq = (acc + RND_HALF) >>> RND_SH;
      if (tq < lo) tq = lo;
      if (tq > hi) tq = hi;
      torque_due.push_back(16'(tq));
      // advance the setpoint schedule after the torque is formed
      setpoint = (tick < rest_ticks) ? '0 : target;
      if (tick > cycle_ticks) tick = '0;
      tick = tick + 1'b1;
    endfunction

    task check_torque(logic signed [ANGLE_W-1:0] got);
      logic signed [ANGLE_W-1:0] due;
      beats++;
      if (torque_due.size() == 0) begin
        report($sformatf("torque beat %0d (%0d) arrived with nothing due", beats, got));
      end else begin
        due = torque_due.pop_front();
        if (got !== due)
          report($sformatf("torque beat %0d: got %0d, due %0d", beats, got, due));
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [ANGLE_W-1:0]  in_measured_angle = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [ANGLE_W-1:0]  out_torque;
  logic                       cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]      cfg_addr = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  torque_board board;

  joint_pid_with_conditional_integral_top #(
    .REST_TICKS (REST_TICKS),
    .CYCLE_TICKS(CYCLE_TICKS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_measured_angle(in_measured_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_torque       (out_torque),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: a fresh coin every cycle at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: everything is sampled at the edge, before the new drive lands.
  // Register writes go first so the model sees them in the same order as the
  // block; then the input beat, then the output beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.write_reg(cfg_addr, cfg_wdata);
      if (in_valid && !in_stall) board.take_angle(in_measured_angle);
      if (out_valid && !out_stall) board.check_torque(out_torque);
    end
  end

  // Offer one angle beat and hold it until taken. Valid stays high on exit so
  // back-to-back beats never drop it; idle cycles are inserted up front.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measured_angle <= angle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write one register; cfg_we is left high for a following write.
  task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Drain the pipeline, then rewrite every register (plus the spare indexes).
  task automatic load_regs(input logic [15:0] kp, kd, ki, win, tgt, mode_word);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.torque_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    put_reg(REG_PROP_GAIN, kp);
    put_reg(SPARE_ADDR_LO, 16'($urandom));
    put_reg(REG_DERIV_GAIN, kd);
    put_reg(REG_INTEG_GAIN, ki);
    put_reg(REG_INTEG_WINDOW, win);
    put_reg(REG_TARGET_ANGLE, tgt);
    put_reg(REG_PID_MODE, mode_word);
    put_reg(SPARE_ADDR_HI, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Either end of the range, a random word, or the caller's moderate value.
  function automatic logic [15:0] pick_word(input logic [15:0] mild);
    case ($urandom_range(3))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return mild;
    endcase
  endfunction

  initial begin
    int seg, r, step, guard;
    logic [15:0] tgt;
    logic signed [ANGLE_W-1:0] walk;

    board = new(REST_TICKS, CYCLE_TICKS);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gains as they come out of reset: no writes yet.
    send_angle(16'sd0);
    send_angle(16'sd4096);
    send_angle(-16'sd4096);

    // PD mode, all gains full, zero window: largest rate swings and
    // saturation at both ends of the torque range.
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFE);
    send_angle(16'sh7FFF);
    send_angle(16'sh8000);
    send_angle(16'sh7FFF);
    send_angle(-16'sd1);
    send_angle(16'sd0);

    // PID mode with the widest window: integrate hard, hit the clamp.
    load_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001);
    send_angle(16'sh8000);
    send_angle(16'sh7FFF);
    send_angle(16'sd100);
    send_angle(-16'sd100);

    // Proportional gain of one half: errors land exactly on rounding ties.
    load_regs(16'd128, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_angle(-16'sd1);
    send_angle(16'sd1);
    send_angle(16'sd3);
    send_angle(16'sd2);

    // Random segments. Together they run past the rest half of the schedule
    // into the target half. Mostly angles that walk around a setpoint so the
    // window gates integration, with full-range noise.
    walk = '0;
    for (seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;          stall_pct = 0;          end
        1: begin send_idle_pct = IDLE_HEAVY; stall_pct = 0;          end
        2: begin send_idle_pct = 0;          stall_pct = IDLE_HEAVY; end
        default: begin send_idle_pct = IDLE_BOTH; stall_pct = IDLE_BOTH; end
      endcase
      if (seg == 4) tgt = 16'h7FFF;
      else if (seg == 5) tgt = 16'h8000;
      else tgt = pick_word(16'($urandom_range(0, 8192) - 4096));
      load_regs(pick_word(16'($urandom_range(0, 2048))),
                pick_word(16'($urandom_range(0, 512))),
                pick_word(16'($urandom_range(0, 256))),
                pick_word(16'($urandom_range(64, 4096))),
                tgt,
                {15'($urandom), 1'(seg)});
      repeat (SEG_BEATS) begin
        r = $urandom_range(99);
        if (r < 8) begin
          walk = (r < 4) ? tgt : '0;     // snap onto one of the setpoints
        end else if (r < 55) begin
          step = int'($urandom_range(0, 64)) - 32;
          walk = 16'(int'(walk) + step);
        end else if (r < 75) begin
          step = int'($urandom_range(0, 4096)) - 2048;
          walk = 16'(int'(walk) + step);
        end else if (r < 90) begin
          walk = 16'($urandom);
        end else begin
          case ($urandom_range(3))
            0: walk = 16'sh7FFF;
            1: walk = 16'sh8000;
            2: walk = 16'sd0;
            default: walk = -16'sd1;
          endcase
        end
        send_angle(walk);
      end
    end

    // Drain: wait for every torque owed, then a few cycles for strays.
    in_valid <= 1'b0;
    guard = 0;
    while (board.torque_due.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.torque_due.size() != 0)
      board.report($sformatf("%0d torque beats never arrived", board.torque_due.size()));

    if (board.faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hdl/jpid_pkg.sv
hdl/jpid_torque.sv
hdl/joint_pid_with_conditional_integral_top.sv
tb/joint_pid_with_conditional_integral_top_test.sv
